FILE: hw/rtl/gcb_pkg.sv
// Shared constants, types and tables for the great-circle bearing unit.
package gcb_pkg;

	localparam int ITERS = 16;
	// Rotation lanes: sine/cosine word, angle word and sideband tag widths.
	localparam int RXW = 19;
	localparam int RZW = 25;
	localparam int RTW = 3;
	// Vectoring lanes: coordinate and angle widths.
	localparam int VXW = 58;
	localparam int VZW = 27;

	localparam int GAIN_Q16 = 39797;
	localparam int ONE_Q16 = 65536;
	localparam int DEG180_Q16 = 11796480;
	localparam int DEG360_Q16 = 23592960;
	localparam int HALF_Q16 = 32768;
	localparam int DEG_FULL = 360;

	// n / 25 is computed as (n * RECIP_25) >> RECIP_SHIFT, exact for n below 2^30.
	localparam logic [28:0] RECIP_25 = 29'd343597384;
	localparam int RECIP_SHIFT = 33;

	typedef enum logic [1:0] {
		SP_NONE,
		SP_ZERO,
		SP_POS90,
		SP_NEG90
	} special_t;

	// Arctangent of 2^-i in degrees, Q16.
	function automatic logic [22:0] atan_q16(input int i);
		logic [22:0] r;
		unique case (i)
			0: r = 23'd2949120;
			1: r = 23'd1740967;
			2: r = 23'd919879;
			3: r = 23'd466945;
			4: r = 23'd234379;
			5: r = 23'd117304;
			6: r = 23'd58666;
			7: r = 23'd29335;
			8: r = 23'd14668;
			9: r = 23'd7334;
			10: r = 23'd3667;
			11: r = 23'd1833;
			12: r = 23'd917;
			13: r = 23'd458;
			14: r = 23'd229;
			15: r = 23'd115;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/gcb_rot_cell.sv
// One CORDIC rotation step, registered, for the sine/cosine lanes.
module gcb_rot_cell import gcb_pkg::*; #(
	parameter int SHIFT = 0,
	parameter int XW = RXW,
	parameter int ZW = RZW,
	parameter int TW = RTW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	input  logic        [TW-1:0] in_tag,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [ZW-1:0] out_z,
	output logic        [TW-1:0] out_tag
);

	localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-23){1'b0}}, atan_q16(SHIFT)});

	logic signed [XW-1:0] dx, dy;

	assign dx = in_y >>> SHIFT;
	assign dy = in_x >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag <= in_tag;
			if (!in_z[ZW-1]) begin
				out_x <= in_x - dx;
				out_y <= in_y + dy;
				out_z <= in_z - ANG;
			end else begin
				out_x <= in_x + dx;
				out_y <= in_y - dy;
				out_z <= in_z + ANG;
			end
		end
	end

endmodule

FILE: hw/rtl/gcb_vec_cell.sv
// One CORDIC vectoring step, registered, for the arctangent lane.
module gcb_vec_cell import gcb_pkg::*; #(
	parameter int SHIFT = 0,
	parameter int XW = VXW,
	parameter int ZW = VZW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	input  logic                 in_zero,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [ZW-1:0] out_z,
	output logic                 out_zero
);

	localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-23){1'b0}}, atan_q16(SHIFT)});

	logic signed [XW-1:0] dx, dy;

	assign dx = in_y >>> SHIFT;
	assign dy = in_x >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_zero <= in_zero;
			if (in_y > 0) begin
				out_x <= in_x + dx;
				out_y <= in_y - dy;
				out_z <= in_z + ANG;
			end else begin
				out_x <= in_x - dx;
				out_y <= in_y + dy;
				out_z <= in_z - ANG;
			end
		end
	end

endmodule

FILE: hw/rtl/great_circle_bearing_unit.sv
// Throughput: one item per cycle; 16 rotation cells per angle lane, 16 vectoring cells
// for the arctangent, and a three-stage product section between them.
// The whole pipeline advances together and holds while a result item waits untaken.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
// Top level of the great-circle initial bearing unit.
module great_circle_bearing_unit import gcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_latitude[14:0], start_longitude[30:15], end_latitude[45:31],
	// end_longitude[61:46], zero[63:62]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// bearing_degrees[8:0], zero[15:9]
	output logic [15:0] m_tdata
);

	logic en;
	assign en = ~m_tvalid | m_tready;
	assign s_tready = en;

	// Input clamp and longitude fold.
	logic signed [14:0] lat1_c, lat2_c;
	logic signed [15:0] lon1_c, lon2_c;
	logic signed [16:0] dlon, dlon_w, dlon_f;
	logic               fold;
	logic signed [14:0] ang_h [3];

	function automatic logic signed [14:0] clamp_lat(input logic signed [14:0] v);
		logic signed [14:0] r;
		if (v > 15'sd9000) r = 15'sd9000;
		else if (v < -15'sd9000) r = -15'sd9000;
		else r = v;
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_lon(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v > 16'sd18000) r = 16'sd18000;
		else if (v < -16'sd18000) r = -16'sd18000;
		else r = v;
		return r;
	endfunction

	always_comb begin
		lat1_c = clamp_lat(s_tdata[14:0]);
		lon1_c = clamp_lon(s_tdata[30:15]);
		lat2_c = clamp_lat(s_tdata[45:31]);
		lon2_c = clamp_lon(s_tdata[61:46]);
		dlon = 17'(lon2_c) - 17'(lon1_c);
		if (dlon > 17'sd18000) dlon_w = dlon - 17'sd36000;
		else if (dlon < -17'sd18000) dlon_w = dlon + 17'sd36000;
		else dlon_w = dlon;
		fold = 1'b0;
		if (dlon_w > 17'sd9000) begin
			dlon_f = dlon_w - 17'sd18000;
			fold = 1'b1;
		end else if (dlon_w < -17'sd9000) begin
			dlon_f = dlon_w + 17'sd18000;
			fold = 1'b1;
		end else begin
			dlon_f = dlon_w;
		end
		ang_h[0] = lat1_c;
		ang_h[1] = lat2_c;
		ang_h[2] = dlon_f[14:0];
	end

	// Stage 1: hundredths to degrees Q16 via reciprocal multiply, lanes lat1, lat2, dlon.
	logic        valid_s1;
	logic [56:0] prod_s1 [3];
	logic        neg_s1  [3];
	logic [RTW-1:0] tag_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_conv
		logic [13:0] mag;
		logic [27:0] num;
		special_t    sp;
		always_comb begin
			mag = ang_h[l][14] ? 14'(-ang_h[l]) : ang_h[l][13:0];
			num = {mag, 14'd0} + 28'd12;
			if (ang_h[l] == 15'sd0) sp = SP_ZERO;
			else if (ang_h[l] == 15'sd9000) sp = SP_POS90;
			else if (ang_h[l] == -15'sd9000) sp = SP_NEG90;
			else sp = SP_NONE;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[l] <= 57'(num) * 57'(RECIP_25);
				neg_s1[l] <= ang_h[l][14];
				tag_s1[l] <= {(l == 2) ? fold : 1'b0, sp};
			end
		end
	end

	// Rotation lanes.
	logic                  rv [3][ITERS+1];
	logic signed [RXW-1:0] rx [3][ITERS+1];
	logic signed [RXW-1:0] ry [3][ITERS+1];
	logic signed [RZW-1:0] rz [3][ITERS+1];
	logic        [RTW-1:0] rt [3][ITERS+1];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic signed [RZW-1:0] q;
		assign q = $signed({1'b0, prod_s1[l][RECIP_SHIFT+RZW-2:RECIP_SHIFT]});
		assign rv[l][0] = valid_s1;
		assign rx[l][0] = RXW'(GAIN_Q16);
		assign ry[l][0] = '0;
		assign rz[l][0] = neg_s1[l] ? -q : q;
		assign rt[l][0] = tag_s1[l];
		for (genvar i = 0; i < ITERS; i++) begin : g_cell
			gcb_rot_cell #(.SHIFT(i), .XW(RXW), .ZW(RZW), .TW(RTW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_valid(rv[l][i]), .in_x(rx[l][i]), .in_y(ry[l][i]),
				.in_z(rz[l][i]), .in_tag(rt[l][i]),
				.out_valid(rv[l][i+1]), .out_x(rx[l][i+1]), .out_y(ry[l][i+1]),
				.out_z(rz[l][i+1]), .out_tag(rt[l][i+1])
			);
		end
	end

	// Exact angles override the CORDIC output; a folded longitude negates both terms.
	logic signed [RXW-1:0] sv [3];
	logic signed [RXW-1:0] cv [3];

	for (genvar l = 0; l < 3; l++) begin : g_fix
		logic signed [RXW-1:0] s0, c0;
		always_comb begin
			unique case (special_t'(rt[l][ITERS][1:0]))
				SP_ZERO: begin
					s0 = '0;
					c0 = RXW'(ONE_Q16);
				end
				SP_POS90: begin
					s0 = RXW'(ONE_Q16);
					c0 = '0;
				end
				SP_NEG90: begin
					s0 = -RXW'(ONE_Q16);
					c0 = '0;
				end
				default: begin
					s0 = ry[l][ITERS];
					c0 = rx[l][ITERS];
				end
			endcase
			sv[l] = rt[l][ITERS][2] ? -s0 : s0;
			cv[l] = rt[l][ITERS][2] ? -c0 : c0;
		end
	end

	// Product stages.
	localparam int PW = 2 * RXW;
	logic                  valid_pa_q, valid_pb_q, valid_pc_q;
	logic signed [PW-1:0]  p1_q, p2_q, p3_q;
	logic signed [RXW-1:0] cd_q;
	logic signed [VXW-1:0] x_q, y_q;
	logic signed [VXW-1:0] vx0_q, vy0_q;
	logic signed [VZW-1:0] vz0_q;
	logic                  vzero0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_pa_q <= 1'b0;
			valid_pb_q <= 1'b0;
			valid_pc_q <= 1'b0;
		end else if (en) begin
			valid_pa_q <= rv[0][ITERS];
			valid_pb_q <= valid_pa_q;
			valid_pc_q <= valid_pb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_q <= PW'(cv[0]) * PW'(sv[1]);
			p2_q <= PW'(sv[0]) * PW'(cv[1]);
			p3_q <= PW'(sv[2]) * PW'(cv[1]);
			cd_q <= cv[2];
			x_q <= (VXW'(p1_q) <<< 16) - VXW'(p2_q) * VXW'(cd_q);
			y_q <= VXW'(p3_q) <<< 16;
			vzero0_q <= (x_q == '0) && (y_q == '0);
			if (x_q[VXW-1]) begin
				vx0_q <= -x_q;
				vy0_q <= -y_q;
				vz0_q <= VZW'(DEG180_Q16);
			end else begin
				vx0_q <= x_q;
				vy0_q <= y_q;
				vz0_q <= '0;
			end
		end
	end

	// Vectoring lane.
	logic                  vv [ITERS+1];
	logic signed [VXW-1:0] vx [ITERS+1];
	logic signed [VXW-1:0] vy [ITERS+1];
	logic signed [VZW-1:0] vz [ITERS+1];
	logic                  vzr [ITERS+1];

	assign vv[0] = valid_pc_q;
	assign vx[0] = vx0_q;
	assign vy[0] = vy0_q;
	assign vz[0] = vz0_q;
	assign vzr[0] = vzero0_q;

	for (genvar i = 0; i < ITERS; i++) begin : g_vec
		gcb_vec_cell #(.SHIFT(i), .XW(VXW), .ZW(VZW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(vv[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]), .in_zero(vzr[i]),
			.out_valid(vv[i+1]), .out_x(vx[i+1]), .out_y(vy[i+1]), .out_z(vz[i+1]),
			.out_zero(vzr[i+1])
		);
	end

	// Normalize, round to whole degrees, wrap 360 to 0; a zero vector gives 0.
	logic signed [VZW-1:0] zn, zr;
	logic [VZW-17:0]       deg_raw;
	logic [8:0]            deg;

	always_comb begin
		zn = vz[ITERS][VZW-1] ? vz[ITERS] + VZW'(DEG360_Q16) : vz[ITERS];
		zr = zn + VZW'(HALF_Q16);
		deg_raw = zr[VZW-1:16];
		if (deg_raw >= (VZW-16)'(DEG_FULL)) deg = 9'(deg_raw - (VZW-16)'(DEG_FULL));
		else deg = deg_raw[8:0];
		if (vzr[ITERS]) deg = '0;
	end

	logic [8:0] bearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vv[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_q <= deg;
		end
	end

	assign m_tdata = {7'd0, bearing_q};

endmodule
